// ===== design/assert_macros.svh =====
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// property that must hold in the cycle after the condition
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== design/jsu_pkg.sv =====
package jsu_pkg;

    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int CP_W        = 16;
    localparam int MAX_RESULTS = 3;
    localparam int CNT_W       = 2;
    localparam int RESULT_DEPTH = 8;

    localparam logic [STATUS_W-1:0] STATUS_CONTENT  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_COMPLETE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ERROR    = 2'd2;

    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_ESC  = 2'd2;
    localparam logic [1:0] PH_HEX  = 2'd3;

    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_N = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_T = 8'h74;
    localparam logic [BYTE_W-1:0] CH_R = 8'h72;
    localparam logic [BYTE_W-1:0] CH_B = 8'h62;
    localparam logic [BYTE_W-1:0] CH_F = 8'h66;
    localparam logic [BYTE_W-1:0] CH_U = 8'h75;

    localparam logic [BYTE_W-1:0] CTL_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CTL_HT = 8'h09;
    localparam logic [BYTE_W-1:0] CTL_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CTL_BS = 8'h08;
    localparam logic [BYTE_W-1:0] CTL_FF = 8'h0C;

    localparam logic [CP_W-1:0] UTF8_ONE_LIMIT = 16'h0080;
    localparam logic [CP_W-1:0] UTF8_TWO_LIMIT = 16'h0800;
    localparam logic [BYTE_W-1:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [BYTE_W-1:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [BYTE_W-1:0] UTF8_CONT  = 8'h80;
    localparam logic [BYTE_W-1:0] UTF8_MASK6 = 8'h3F;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic [STATUS_W-1:0] status;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [1:0]      phase;
        logic [1:0]      digits;
        logic [CP_W-1:0] code_point;
        logic            stopped;
    } jsu_state_t;

    typedef struct packed {
        jsu_state_t                   next;
        logic [CNT_W-1:0]             count;
        result_t [MAX_RESULTS-1:0]    res;
    } jsu_step_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
        hex_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end
        else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

// ===== design/jsu_channels.sv =====
interface jsu_in_if;
    import jsu_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              text_end;
    modport source (output valid, output in_byte, output text_end, input ready);
    modport sink (input valid, input in_byte, input text_end, output ready);
endinterface

interface jsu_out_if;
    import jsu_pkg::*;
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_byte;
    logic [STATUS_W-1:0] status;
    logic                last;
    modport source (output valid, output out_byte, output status, output last, input ready);
    modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface

// ===== design/jsu_decode.sv =====
module jsu_decode (
    input  jsu_pkg::jsu_state_t           state,
    input  logic [jsu_pkg::BYTE_W-1:0]    in_byte,
    input  logic                          text_end,
    output jsu_pkg::jsu_step_t            step
);
    import jsu_pkg::*;

    hex_t            hex;
    logic [CP_W-1:0] cp_acc;
    logic            stop_acc;

    always_comb
    begin
        hex      = hex_decode(in_byte);
        cp_acc   = state.code_point;
        stop_acc = state.stopped;
        if (!state.stopped) begin
            if (hex.valid) begin
                cp_acc = {state.code_point[CP_W-5:0], hex.value};
            end
            else begin
                stop_acc = 1'b1;
            end
        end
    end

    always_comb
    begin
        step       = '0;
        step.next  = state;
        if (text_end) begin
            if (state.phase != PH_WAIT) begin
                step.count         = 2'd1;
                step.res[0].status = STATUS_ERROR;
                step.next.phase    = PH_WAIT;
            end
        end
        else begin
            unique case (state.phase)
                PH_WAIT:
                begin
                    if (in_byte == CH_QUOTE) begin
                        step.next.phase = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (in_byte == CH_QUOTE) begin
                        step.count         = 2'd1;
                        step.res[0].status = STATUS_COMPLETE;
                        step.next.phase    = PH_WAIT;
                    end
                    else if (in_byte == CH_BSLASH) begin
                        step.next.phase = PH_ESC;
                    end
                    else begin
                        step.count           = 2'd1;
                        step.res[0].out_byte = in_byte;
                    end
                end
                PH_ESC:
                begin
                    step.next.phase = PH_BODY;
                    step.count      = 2'd1;
                    case (in_byte)
                        CH_N: step.res[0].out_byte = CTL_LF;
                        CH_T: step.res[0].out_byte = CTL_HT;
                        CH_R: step.res[0].out_byte = CTL_CR;
                        CH_B: step.res[0].out_byte = CTL_BS;
                        CH_F: step.res[0].out_byte = CTL_FF;
                        CH_U:
                        begin
                            step.count           = 2'd0;
                            step.next.phase      = PH_HEX;
                            step.next.digits     = 2'd0;
                            step.next.code_point = '0;
                            step.next.stopped    = 1'b0;
                        end
                        default: step.res[0].out_byte = in_byte;
                    endcase
                end
                PH_HEX:
                begin
                    if (state.digits == 2'd3) begin
                        // fourth hex byte of the escape, encode as utf-8
                        if (cp_acc < UTF8_ONE_LIMIT) begin
                            step.count           = 2'd1;
                            step.res[0].out_byte = cp_acc[BYTE_W-1:0];
                        end
                        else if (cp_acc < UTF8_TWO_LIMIT) begin
                            step.count           = 2'd2;
                            step.res[0].out_byte = UTF8_LEAD2 | {3'd0, cp_acc[10:6]};
                            step.res[1].out_byte = UTF8_CONT | ({2'd0, cp_acc[5:0]} & UTF8_MASK6);
                        end
                        else begin
                            step.count           = 2'd3;
                            step.res[0].out_byte = UTF8_LEAD3 | {4'd0, cp_acc[15:12]};
                            step.res[1].out_byte = UTF8_CONT | ({2'd0, cp_acc[11:6]} & UTF8_MASK6);
                            step.res[2].out_byte = UTF8_CONT | ({2'd0, cp_acc[5:0]} & UTF8_MASK6);
                        end
                        step.next.phase      = PH_BODY;
                        step.next.digits     = 2'd0;
                        step.next.code_point = '0;
                        step.next.stopped    = 1'b0;
                    end
                    else begin
                        step.next.digits     = state.digits + 2'd1;
                        step.next.code_point = cp_acc;
                        step.next.stopped    = stop_acc;
                    end
                end
                default: step.next.phase = PH_WAIT;
            endcase
        end

        case (step.count)
            2'd1:    step.res[0].last = 1'b1;
            2'd2:    step.res[1].last = 1'b1;
            2'd3:    step.res[2].last = 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== design/jsu_result_fifo.sv =====
module jsu_result_fifo #(
    parameter int DEPTH = jsu_pkg::RESULT_DEPTH
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic [jsu_pkg::CNT_W-1:0]                   push_cnt,
    input  jsu_pkg::result_t [jsu_pkg::MAX_RESULTS-1:0] push_data,
    output logic                                        room,
    jsu_out_if.source                                   out_ch
);
    import jsu_pkg::*;

    `include "assert_macros.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    result_t       mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [AW-1:0] wr_idx [MAX_RESULTS];
    logic [AW:0]   sum;
    logic          pop;
    result_t       head;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [AW:0] offs);
        logic [AW:0] s;
        s = {1'b0, base} + offs;
        if (s >= (AW + 1)'(DEPTH)) begin
            s = s - (AW + 1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            wr_idx[i] = wrap_add(wr_ptr_reg, (AW + 1)'(i));
        end
        sum         = (AW + 1)'(push_cnt);
        wr_ptr_next = wrap_add(wr_ptr_reg, sum);
        rd_ptr_next = pop ? wrap_add(rd_ptr_reg, (AW + 1)'(1)) : rd_ptr_reg;
        count_next  = count_reg + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (CNT_W'(i) < push_cnt) begin
                mem[wr_idx[i]] <= push_data[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head            = mem[rd_ptr_reg];
    assign room            = count_reg <= CW'(DEPTH - MAX_RESULTS);
    assign pop             = out_ch.valid && out_ch.ready;
    assign out_ch.valid    = count_reg != '0;
    assign out_ch.out_byte = head.out_byte;
    assign out_ch.status   = head.status;
    assign out_ch.last     = head.last;

    `ASSERT_CLK(a_count_bound, count_reg <= CW'(DEPTH), "result queue overfilled")
    `ASSERT_IMPL(a_push_fits, push_cnt != '0,
        (CW + 1)'(count_reg) + (CW + 1)'(push_cnt) <= (CW + 1)'(DEPTH), "push past free space")
    `ASSERT_NEXT(a_count_track, push_cnt != '0 && !pop,
        count_reg == $past(count_reg) + CW'($past(push_cnt)), "queue count lost a word")

endmodule

// ===== design/json_string_unescaper_core.sv =====
// channel | dir | payload                     | handshake
// in_ch   | in  | in_byte[7:0], text_end      | valid/ready
// out_ch  | out | out_byte[7:0], status, last | valid/ready
//
// one input word is decoded per cycle while the queue has room; a \u escape yields
// up to three output words at its fourth hex byte, the rest one word or none
// decoded words go through a DEPTH-entry queue, input ready needs three free entries
// output words leave at one per cycle; out_ch.ready low only fills the queue
// rst_n clears the parser state and the queue at once, no clearing pass
module json_string_unescaper_core #(
    parameter int DEPTH = jsu_pkg::RESULT_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    jsu_in_if.sink     in_ch,
    jsu_out_if.source  out_ch
);
    import jsu_pkg::*;

    `include "assert_macros.svh"

    jsu_state_t       state_reg;
    jsu_state_t       state_next;
    jsu_step_t        step;
    logic             room;
    logic             accept;
    logic [CNT_W-1:0] push_cnt;

    jsu_decode u_decode (
        .state    (state_reg),
        .in_byte  (in_ch.in_byte),
        .text_end (in_ch.text_end),
        .step     (step)
    );

    jsu_result_fifo #(
        .DEPTH (DEPTH)
    ) u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_data (step.res),
        .room      (room),
        .out_ch    (out_ch)
    );

    assign in_ch.ready = room;
    assign accept      = in_ch.valid && in_ch.ready;
    assign push_cnt    = accept ? step.count : '0;
    assign state_next  = accept ? step.next : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg.phase      <= PH_WAIT;
            state_reg.digits     <= '0;
            state_reg.code_point <= '0;
            state_reg.stopped    <= 1'b0;
        end
        else begin
            state_reg <= state_next;
        end
    end

    `ASSERT_IMPL(a_hex_emits, accept && !in_ch.text_end && state_reg.phase == PH_HEX &&
        state_reg.digits == 2'd3, push_cnt != '0, "escape ended without output")
    `ASSERT_NEXT(a_end_resets, accept && in_ch.text_end, state_reg.phase == PH_WAIT,
        "text end left parser inside string")
    `ASSERT_IMPL(a_wait_silent, accept && state_reg.phase == PH_WAIT, push_cnt == '0,
        "output while waiting for quote")

endmodule
